FILE: rtl/core/aesst_pkg.sv
// Package for the AES state transform unit: beat types, command codes,
// S-box tables and a GF(2^8) helper function. No dependencies.
`timescale 1ns / 1ps

package aesst_pkg;

    // Command codes carried in the command field; the two spare codes pass the state through
    typedef enum logic [2:0] {
        CMD_SUB_BYTES       = 3'd0,
        CMD_INV_SUB_BYTES   = 3'd1,
        CMD_SHIFT_ROWS      = 3'd2,
        CMD_INV_SHIFT_ROWS  = 3'd3,
        CMD_MIX_COLUMNS     = 3'd4,
        CMD_INV_MIX_COLUMNS = 3'd5,
        CMD_SPARE_A         = 3'd6,
        CMD_SPARE_B         = 3'd7
    } aesst_cmd_t;

    localparam int unsigned NUM_BYTES = 16;
    localparam logic [7:0] RED_POLY   = 8'h1b;
    localparam logic [7:0] TOP_BIT    = 8'h80;

    typedef logic [7:0] aesst_byte_t;
    typedef aesst_byte_t aesst_state_t [NUM_BYTES];

    // Input beat
    typedef struct packed {
        logic [2:0]  command;
        logic [63:0] state_hi;
        logic [63:0] state_lo;
    } aesst_in_t;

    // Result beat
    typedef struct packed {
        logic [63:0] result_hi;
        logic [63:0] result_lo;
    } aesst_out_t;

    // Forward S-box
    localparam aesst_byte_t SBOX_FWD [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // Inverse S-box
    localparam aesst_byte_t SBOX_INV [256] = '{
        8'h52, 8'h09, 8'h6a, 8'hd5, 8'h30, 8'h36, 8'ha5, 8'h38,
        8'hbf, 8'h40, 8'ha3, 8'h9e, 8'h81, 8'hf3, 8'hd7, 8'hfb,
        8'h7c, 8'he3, 8'h39, 8'h82, 8'h9b, 8'h2f, 8'hff, 8'h87,
        8'h34, 8'h8e, 8'h43, 8'h44, 8'hc4, 8'hde, 8'he9, 8'hcb,
        8'h54, 8'h7b, 8'h94, 8'h32, 8'ha6, 8'hc2, 8'h23, 8'h3d,
        8'hee, 8'h4c, 8'h95, 8'h0b, 8'h42, 8'hfa, 8'hc3, 8'h4e,
        8'h08, 8'h2e, 8'ha1, 8'h66, 8'h28, 8'hd9, 8'h24, 8'hb2,
        8'h76, 8'h5b, 8'ha2, 8'h49, 8'h6d, 8'h8b, 8'hd1, 8'h25,
        8'h72, 8'hf8, 8'hf6, 8'h64, 8'h86, 8'h68, 8'h98, 8'h16,
        8'hd4, 8'ha4, 8'h5c, 8'hcc, 8'h5d, 8'h65, 8'hb6, 8'h92,
        8'h6c, 8'h70, 8'h48, 8'h50, 8'hfd, 8'hed, 8'hb9, 8'hda,
        8'h5e, 8'h15, 8'h46, 8'h57, 8'ha7, 8'h8d, 8'h9d, 8'h84,
        8'h90, 8'hd8, 8'hab, 8'h00, 8'h8c, 8'hbc, 8'hd3, 8'h0a,
        8'hf7, 8'he4, 8'h58, 8'h05, 8'hb8, 8'hb3, 8'h45, 8'h06,
        8'hd0, 8'h2c, 8'h1e, 8'h8f, 8'hca, 8'h3f, 8'h0f, 8'h02,
        8'hc1, 8'haf, 8'hbd, 8'h03, 8'h01, 8'h13, 8'h8a, 8'h6b,
        8'h3a, 8'h91, 8'h11, 8'h41, 8'h4f, 8'h67, 8'hdc, 8'hea,
        8'h97, 8'hf2, 8'hcf, 8'hce, 8'hf0, 8'hb4, 8'he6, 8'h73,
        8'h96, 8'hac, 8'h74, 8'h22, 8'he7, 8'had, 8'h35, 8'h85,
        8'he2, 8'hf9, 8'h37, 8'he8, 8'h1c, 8'h75, 8'hdf, 8'h6e,
        8'h47, 8'hf1, 8'h1a, 8'h71, 8'h1d, 8'h29, 8'hc5, 8'h89,
        8'h6f, 8'hb7, 8'h62, 8'h0e, 8'haa, 8'h18, 8'hbe, 8'h1b,
        8'hfc, 8'h56, 8'h3e, 8'h4b, 8'hc6, 8'hd2, 8'h79, 8'h20,
        8'h9a, 8'hdb, 8'hc0, 8'hfe, 8'h78, 8'hcd, 8'h5a, 8'hf4,
        8'h1f, 8'hdd, 8'ha8, 8'h33, 8'h88, 8'h07, 8'hc7, 8'h31,
        8'hb1, 8'h12, 8'h10, 8'h59, 8'h27, 8'h80, 8'hec, 8'h5f,
        8'h60, 8'h51, 8'h7f, 8'ha9, 8'h19, 8'hb5, 8'h4a, 8'h0d,
        8'h2d, 8'he5, 8'h7a, 8'h9f, 8'h93, 8'hc9, 8'h9c, 8'hef,
        8'ha0, 8'he0, 8'h3b, 8'h4d, 8'hae, 8'h2a, 8'hf5, 8'hb0,
        8'hc8, 8'heb, 8'hbb, 8'h3c, 8'h83, 8'h53, 8'h99, 8'h61,
        8'h17, 8'h2b, 8'h04, 8'h7e, 8'hba, 8'h77, 8'hd6, 8'h26,
        8'he1, 8'h69, 8'h14, 8'h63, 8'h55, 8'h21, 8'h0c, 8'h7d
    };

    // Multiply by x in GF(2^8), reduction polynomial 0x11b
    function automatic aesst_byte_t xtime(input aesst_byte_t b);
        aesst_byte_t s;
        s = {b[6:0], 1'b0};
        if ((b & TOP_BIT) != 8'h00)
        begin
            s = s ^ RED_POLY;
        end
        return s;
    endfunction

endpackage : aesst_pkg

FILE: rtl/core/aes_state_transform_unit_core.sv
// AES round transform unit, top level: input register, one combinational
// transform, result register. Depends on aesst_pkg.
`timescale 1ns / 1ps

// Applies one AES round transform (SubBytes, InvSubBytes, ShiftRows,
// InvShiftRows, MixColumns, InvMixColumns) to a 128-bit state, bytes held
// row-major with byte 0 in the top bits of state_hi. Command codes 6 and 7
// pass the state through unchanged. One beat is accepted every cycle while
// the result side can move. Each beat goes from the input register through
// the transform logic (sixteen S-box table lookups or the column mixing
// network), whose output lands in the result register.
// The result register and the input register stall independently, so a new
// beat is taken whenever the result side can move or the input register is
// empty.
module aes_state_transform_unit_core
    import aesst_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_ready,
    input  aesst_in_t  item,
    output logic       result_valid,
    input  logic       result_ready,
    output aesst_out_t result
);

    aesst_in_t    in_reg;
    logic         in_valid_reg;
    aesst_out_t   out_reg;
    logic         out_valid_reg;
    aesst_out_t   out_next;
    logic         out_adv;
    logic         in_take;
    logic [127:0] in_word;
    logic [127:0] out_word;
    aesst_state_t st;
    aesst_state_t res;
    aesst_state_t pre;
    aesst_byte_t  t_col;
    aesst_byte_t  u_col;
    aesst_byte_t  v_col;

    // Stage handshakes
    assign out_adv    = !out_valid_reg || result_ready;
    assign item_ready = !in_valid_reg || out_adv;
    assign in_take    = item_valid && item_ready;

    // Unpack the state into bytes
    assign in_word = {in_reg.state_hi, in_reg.state_lo};
    always_comb
    begin
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            st[i] = in_word[127 - 8 * i -: 8];
        end
    end

    // Transform
    always_comb
    begin
        t_col = 8'h00;
        u_col = 8'h00;
        v_col = 8'h00;
        pre   = st;
        res   = st;
        case (aesst_cmd_t'(in_reg.command))
            CMD_SUB_BYTES:
            begin
                for (int i = 0; i < NUM_BYTES; i++)
                begin
                    res[i] = SBOX_FWD[st[i]];
                end
            end
            CMD_INV_SUB_BYTES:
            begin
                for (int i = 0; i < NUM_BYTES; i++)
                begin
                    res[i] = SBOX_INV[st[i]];
                end
            end
            CMD_SHIFT_ROWS:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        res[4 * r + c] = st[4 * r + ((c + r) % 4)];
                    end
                end
            end
            CMD_INV_SHIFT_ROWS:
            begin
                for (int r = 0; r < 4; r++)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        res[4 * r + c] = st[4 * r + ((c + 4 - r) % 4)];
                    end
                end
            end
            CMD_MIX_COLUMNS, CMD_INV_MIX_COLUMNS:
            begin
                // inverse: premultiply by {04} on alternating pairs first
                if (aesst_cmd_t'(in_reg.command) == CMD_INV_MIX_COLUMNS)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        u_col = xtime(xtime(st[c] ^ st[8 + c]));
                        v_col = xtime(xtime(st[4 + c] ^ st[12 + c]));
                        pre[c]      = st[c] ^ u_col;
                        pre[4 + c]  = st[4 + c] ^ v_col;
                        pre[8 + c]  = st[8 + c] ^ u_col;
                        pre[12 + c] = st[12 + c] ^ v_col;
                    end
                end
                for (int c = 0; c < 4; c++)
                begin
                    t_col = pre[c] ^ pre[4 + c] ^ pre[8 + c] ^ pre[12 + c];
                    res[c]      = pre[c] ^ t_col ^ xtime(pre[c] ^ pre[4 + c]);
                    res[4 + c]  = pre[4 + c] ^ t_col ^ xtime(pre[4 + c] ^ pre[8 + c]);
                    res[8 + c]  = pre[8 + c] ^ t_col ^ xtime(pre[8 + c] ^ pre[12 + c]);
                    res[12 + c] = pre[12 + c] ^ t_col ^ xtime(pre[12 + c] ^ pre[c]);
                end
            end
            default:
            begin
                res = st;
            end
        endcase
    end

    // Repack
    always_comb
    begin
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            out_word[127 - 8 * i -: 8] = res[i];
        end
    end
    assign out_next = '{result_hi: out_word[127:64], result_lo: out_word[63:0]};

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                in_valid_reg <= item_valid;
            end
            if (out_adv)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_reg <= item;
        end
        if (out_adv && in_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Checks
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        result_ready |-> item_ready)
        else $error("input stalled while result side is draining");

    a_take_fills_input: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> in_valid_reg && (in_reg == $past(item)))
        else $error("accepted beat not held in input register");

    a_input_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !out_adv) |=> in_valid_reg && $stable(in_reg))
        else $error("input register lost a beat while stalled");

    a_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (out_adv && in_valid_reg
            && (in_reg.command == CMD_SPARE_A || in_reg.command == CMD_SPARE_B))
        |=> (out_reg.result_hi == $past(in_reg.state_hi))
            && (out_reg.result_lo == $past(in_reg.state_lo)))
        else $error("unused command code altered the state");

endmodule : aes_state_transform_unit_core

FILE: tb/testbench.sv
// Self-checking testbench for the AES state transform unit (aes_state_transform_unit_core).
// It predicts each result from its own GF(2^8) round-transform model and
// compares it with the DUT under random back-pressure. Depends on aesst_pkg.
`timescale 1ns / 1ps

module testbench;
    import aesst_pkg::*;

    localparam logic [7:0] FIELD_POLY  = 8'h1b;
    localparam logic [7:0] MSB_MASK    = 8'h80;
    localparam logic [7:0] AFFINE_K    = 8'h63;
    localparam logic [7:0] INV_AFFINE_K = 8'h05;

    localparam int RANDOM_BEATS  = 1000;
    localparam int TAIL_BEATS    = 150;
    localparam int HOLDOFF_AFTER = 400;
    localparam int HOLDOFF_LEN   = 120;
    localparam int DRAIN_CYCLES  = 12;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       item_valid = 1'b0;
    logic       item_ready;
    aesst_in_t  item = '0;
    logic       result_valid;
    logic       result_ready = 1'b0;
    aesst_out_t result;

    aesst_in_t  pending_beats [$];
    aesst_out_t expected_states [$];
    int         accepted_count = 0;
    int         mismatch_count = 0;
    int         send_gap = 0;
    int         recv_gap = 0;
    logic       tail_phase = 1'b0;
    logic       hold_results = 1'b0;
    logic       idle_allowed;

    logic [2:0] cmd_list [8] = '{CMD_SUB_BYTES, CMD_INV_SUB_BYTES, CMD_SHIFT_ROWS,
                                 CMD_INV_SHIFT_ROWS, CMD_MIX_COLUMNS,
                                 CMD_INV_MIX_COLUMNS, CMD_SPARE_A, CMD_SPARE_B};

    aes_state_transform_unit_core DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Idling alternates in 64-beat stretches and stops for the tail
    assign idle_allowed = !tail_phase && !accepted_count[6];

    // ---------------- GF(2^8) model of the round transforms ----------------

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        logic [7:0] s;
        s = {b[6:0], 1'b0};
        if ((b & MSB_MASK) != 8'h00)
        begin
            s = s ^ FIELD_POLY;
        end
        return s;
    endfunction

    function automatic logic [7:0] gf_product(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] acc;
        acc = 8'h00;
        for (int k = 0; k < 8; k++)
        begin
            if (b[0])
            begin
                acc = acc ^ a;
            end
            a = gf_double(a);
            b = b >> 1;
        end
        return acc;
    endfunction

    // x^254; zero maps to zero
    function automatic logic [7:0] gf_reciprocal(input logic [7:0] x);
        logic [7:0] p;
        logic [7:0] r;
        p = x;
        r = 8'h01;
        for (int k = 0; k < 7; k++)
        begin
            p = gf_product(p, p);
            r = gf_product(r, p);
        end
        return (x == 8'h00) ? 8'h00 : r;
    endfunction

    function automatic logic [7:0] rot_left(input logic [7:0] v, input int n);
        return (v << n) | (v >> (8 - n));
    endfunction

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        logic [7:0] b;
        b = gf_reciprocal(x);
        return b ^ rot_left(b, 1) ^ rot_left(b, 2) ^ rot_left(b, 3) ^ rot_left(b, 4)
            ^ AFFINE_K;
    endfunction

    function automatic logic [7:0] inv_sub_byte(input logic [7:0] s);
        return gf_reciprocal(rot_left(s, 1) ^ rot_left(s, 3) ^ rot_left(s, 6)
            ^ INV_AFFINE_K);
    endfunction

    // Expected state after one round transform
    function automatic aesst_out_t transform_state(input aesst_in_t beat);
        logic [7:0] st [16];
        logic [7:0] src [16];
        logic [7:0] a0, a1, a2, a3, t, u, v;
        aesst_out_t res;
        for (int i = 0; i < 8; i++)
        begin
            st[i]     = beat.state_hi[63 - 8 * i -: 8];
            st[8 + i] = beat.state_lo[63 - 8 * i -: 8];
        end
        src = st;
        case (beat.command)
            CMD_SUB_BYTES:
            begin
                for (int i = 0; i < 16; i++) st[i] = sub_byte(st[i]);
            end
            CMD_INV_SUB_BYTES:
            begin
                for (int i = 0; i < 16; i++) st[i] = inv_sub_byte(st[i]);
            end
            CMD_SHIFT_ROWS:
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        st[4 * r + c] = src[4 * r + ((c + r) & 3)];
            end
            CMD_INV_SHIFT_ROWS:
            begin
                for (int r = 0; r < 4; r++)
                    for (int c = 0; c < 4; c++)
                        st[4 * r + c] = src[4 * r + ((c + 4 - r) & 3)];
            end
            CMD_MIX_COLUMNS, CMD_INV_MIX_COLUMNS:
            begin
                // inverse: premultiply column pairs by {04}, then mix
                if (beat.command == CMD_INV_MIX_COLUMNS)
                begin
                    for (int c = 0; c < 4; c++)
                    begin
                        u = gf_double(gf_double(st[c] ^ st[8 + c]));
                        v = gf_double(gf_double(st[4 + c] ^ st[12 + c]));
                        st[c]      = st[c] ^ u;
                        st[4 + c]  = st[4 + c] ^ v;
                        st[8 + c]  = st[8 + c] ^ u;
                        st[12 + c] = st[12 + c] ^ v;
                    end
                end
                for (int c = 0; c < 4; c++)
                begin
                    a0 = st[c];
                    a1 = st[4 + c];
                    a2 = st[8 + c];
                    a3 = st[12 + c];
                    t  = a0 ^ a1 ^ a2 ^ a3;
                    st[c]      = a0 ^ t ^ gf_double(a0 ^ a1);
                    st[4 + c]  = a1 ^ t ^ gf_double(a1 ^ a2);
                    st[8 + c]  = a2 ^ t ^ gf_double(a2 ^ a3);
                    st[12 + c] = a3 ^ t ^ gf_double(a3 ^ a0);
                end
            end
            default:
            begin
                // spare codes pass the state through
            end
        endcase
        for (int i = 0; i < 8; i++)
        begin
            res.result_hi[63 - 8 * i -: 8] = st[i];
            res.result_lo[63 - 8 * i -: 8] = st[8 + i];
        end
        return res;
    endfunction

    // ---------------- Checking ----------------

    task automatic report_mismatch(input string msg);
        $display("[%0t] ERROR: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Driver: offers pending beats, predicts each accepted one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item       <= '0;
        end
        else if (!item_valid || item_ready)
        begin
            if (item_valid)
            begin
                expected_states.push_back(transform_state(item));
                accepted_count <= accepted_count + 1;
                if (idle_allowed && $urandom_range(0, 3) == 0)
                begin
                    send_gap = $urandom_range(1, 3);
                end
            end
            if (send_gap > 0)
            begin
                send_gap--;
                item_valid <= 1'b0;
            end
            else if (pending_beats.size() > 0)
            begin
                item       <= pending_beats.pop_front();
                item_valid <= 1'b1;
            end
            else
            begin
                item_valid <= 1'b0;
            end
        end
    end

    // Monitor: compares each result beat, drives result_ready
    always @(posedge clk or negedge rst_n)
    begin
        aesst_out_t want;
        if (!rst_n)
        begin
            result_ready <= 1'b0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_states.size() == 0)
                begin
                    report_mismatch($sformatf("result beat with none expected: %032h",
                        result));
                end
                else
                begin
                    want = expected_states.pop_front();
                    if (result.result_hi !== want.result_hi)
                        report_mismatch($sformatf("result_hi got %016h want %016h",
                            result.result_hi, want.result_hi));
                    if (result.result_lo !== want.result_lo)
                        report_mismatch($sformatf("result_lo got %016h want %016h",
                            result.result_lo, want.result_lo));
                end
            end
            if (hold_results)
            begin
                result_ready <= 1'b0;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                result_ready <= 1'b0;
            end
            else if (idle_allowed && $urandom_range(0, 4) == 0)
            begin
                recv_gap = $urandom_range(0, 2);
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
            end
        end
    end

    // ---------------- Stimulus ----------------

    // Reset, then release
    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Checked on the falling edge, once the driver and monitor have settled
    task automatic wait_for_drain();
        @(negedge clk);
        while (pending_beats.size() > 0 || item_valid || expected_states.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        aesst_in_t beat;
        @(posedge clk);
        while (!rst_n) @(posedge clk);

        // Directed: every code on all-zero, all-one and one random state
        for (int k = 0; k < 8; k++)
        begin
            beat.command  = cmd_list[k];
            beat.state_hi = '0;
            beat.state_lo = '0;
            pending_beats.push_back(beat);
            beat.state_hi = '1;
            beat.state_lo = '1;
            pending_beats.push_back(beat);
            beat.state_hi = {$urandom, $urandom};
            beat.state_lo = {$urandom, $urandom};
            pending_beats.push_back(beat);
        end

        // Sender pauses until every directed result is back
        wait_for_drain();

        // Random: mostly real transforms, some spare codes
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if ($urandom_range(0, 9) == 0)
                beat.command = cmd_list[$urandom_range(6, 7)];
            else
                beat.command = cmd_list[$urandom_range(0, 5)];
            beat.state_hi = {$urandom, $urandom};
            beat.state_lo = {$urandom, $urandom};
            pending_beats.push_back(beat);
        end

        wait_for_drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Quiet tail: no idling once few beats remain
    initial
    begin
        @(posedge clk);
        while (!rst_n || accepted_count < HOLDOFF_AFTER || pending_beats.size() >= TAIL_BEATS)
            @(posedge clk);
        tail_phase <= 1'b1;
    end

    // Long receiver hold-off so the block fills and stalls its input
    initial
    begin
        @(posedge clk);
        while (accepted_count < HOLDOFF_AFTER) @(posedge clk);
        hold_results <= 1'b1;
        repeat (HOLDOFF_LEN) @(posedge clk);
        hold_results <= 1'b0;
    end

    // Watchdog
    initial
    begin
        #1000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/aesst_pkg.sv
rtl/core/aes_state_transform_unit_core.sv
tb/testbench.sv
